// File: hdl/mpwc_pkg.sv
// ----------------------------------------------------------------------------
// mpwc_pkg
// Shared types and constants of the multichannel pulse width capture block.
// ----------------------------------------------------------------------------
package mpwc_pkg;

    localparam int TIME_W      = 32;
    localparam int LEVEL_W     = 32;
    localparam int LEVEL_MSB   = 31;
    localparam int IDX_W       = 3;
    localparam int MAX_RESULTS = 8;
    localparam int RCNT_W      = 4;
    localparam int EVQ_DEPTH   = 4;
    localparam int EVQ_AW      = 2;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Number of 2^32 ns epoch boundaries crossed since a channel's last change.
    localparam logic [1:0] AGE_ZERO = 2'd0;
    localparam logic [1:0] AGE_ONE  = 2'd1;
    localparam logic [1:0] AGE_SAT  = 2'd2;

    typedef struct packed {
        logic [LEVEL_W-1:0] level_bits;
        logic [TIME_W-1:0]  time_delta;
    } sample_t;

    typedef struct packed {
        logic [IDX_W-1:0]  channel_index;
        logic              ended_level;
        logic [TIME_W-1:0] pulse_len;
        logic              last_of_run;
    } result_t;

    function automatic logic [1:0] age_inc(input logic [1:0] age);
        logic [1:0] r;
        case (age)
            AGE_ZERO: r = AGE_ONE;
            AGE_ONE:  r = AGE_SAT;
            default:  r = AGE_SAT;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/mpwc_front.sv
// ----------------------------------------------------------------------------
// mpwc_front
// Sample stage: holds levels, epoch ages and the global time, and builds
// one event per sample that changes at least one channel.
// ----------------------------------------------------------------------------
module mpwc_front #(
    parameter int CHANNELS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          sample_accept,
    input  mpwc_pkg::sample_t             sample,
    output logic                          evt_push,
    output logic [CHANNELS-1:0]           evt_mask,
    output logic [CHANNELS-1:0]           evt_level,
    output logic [CHANNELS-1:0][1:0]      evt_age,
    output logic [mpwc_pkg::TIME_W-1:0]   evt_time
);
    import mpwc_pkg::*;

    logic [CHANNELS-1:0]      held_reg, held_next;
    logic [CHANNELS-1:0][1:0] age_reg, age_next;
    logic [TIME_W-1:0]        time_reg, time_next;
    logic [TIME_W:0]          time_sum;
    logic [CHANNELS-1:0]      lvl;
    logic [CHANNELS-1:0][1:0] age_eff;

    assign time_sum = {1'b0, time_reg} + {1'b0, sample.time_delta};

    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            lvl[i]     = sample.level_bits[LEVEL_MSB - i];
            age_eff[i] = time_sum[TIME_W] ? age_inc(age_reg[i]) : age_reg[i];
        end
    end

    assign evt_mask  = lvl ^ held_reg;
    assign evt_level = held_reg;
    assign evt_age   = age_eff;
    assign evt_time  = time_sum[TIME_W-1:0];
    assign evt_push  = sample_accept && (|evt_mask);

    always_comb begin
        held_next = held_reg;
        age_next  = age_reg;
        time_next = time_reg;
        if (sample_accept) begin
            held_next = lvl;
            time_next = time_sum[TIME_W-1:0];
            for (int i = 0; i < CHANNELS; i++) begin
                age_next[i] = evt_mask[i] ? AGE_ZERO : age_eff[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
            age_reg  <= '0;
            time_reg <= '0;
        end else begin
            held_reg <= held_next;
            age_reg  <= age_next;
            time_reg <= time_next;
        end
    end

endmodule

// File: hdl/mpwc_evq.sv
// ----------------------------------------------------------------------------
// mpwc_evq
// Small first-in first-out queue of change events.
// ----------------------------------------------------------------------------
module mpwc_evq #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             empty,
    output logic             full
);
    import mpwc_pkg::*;

    logic [WIDTH-1:0]    slot_mem [EVQ_DEPTH];
    logic [EVQ_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [EVQ_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [EVQ_AW:0]     count_reg, count_next;
    logic                do_push, do_pop;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == (EVQ_AW+1)'(EVQ_DEPTH));
    assign head_data = slot_mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hdl/mpwc_drain.sv
// ----------------------------------------------------------------------------
// mpwc_drain
// Walks the changed channels of the head event one per cycle unless the
// output stalls, reads each channel's start time from memory, writes the
// new start back and emits each reported width into the output register.
// ----------------------------------------------------------------------------
module mpwc_drain #(
    parameter int CHANNELS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          head_valid,
    input  logic [CHANNELS-1:0]           head_mask,
    input  logic [CHANNELS-1:0]           head_level,
    input  logic [CHANNELS-1:0][1:0]      head_age,
    input  logic [mpwc_pkg::TIME_W-1:0]   head_time,
    output logic                          head_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output mpwc_pkg::result_t             m_data
);
    import mpwc_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // start time memory, one entry per channel
    logic [TIME_W-1:0]   start_mem [CHANNELS];
    logic [TIME_W-1:0]   rd_data_reg;
    logic [CHANNELS-1:0] written_reg, written_next;

    // pick stage
    logic [CHANNELS-1:0] done_reg, done_next;
    logic [RCNT_W-1:0]   rep_cnt_reg, rep_cnt_next;
    logic [CHANNELS-1:0] rem, rem_after, pick_hot;
    logic [CH_W-1:0]     pick;
    logic                pick_report, pick_last, a_fire;

    // width stage
    logic                b_valid_reg;
    logic [CH_W-1:0]     b_ch_reg;
    logic [1:0]          b_age_reg;
    logic [TIME_W-1:0]   b_time_reg;
    logic                b_level_reg, b_report_reg, b_last_reg;

    // last write, for a read that raced it
    logic                fwd_valid_reg;
    logic [CH_W-1:0]     fwd_ch_reg;
    logic [TIME_W-1:0]   fwd_time_reg;

    logic                m_valid_reg, m_valid_next;
    result_t             m_data_reg;

    logic [TIME_W-1:0]   start_time, diff;
    logic [TIME_W-1:0]   width;
    logic                adv, out_load;

    // lowest pending channel
    always_comb begin
        rem  = head_mask & ~done_reg;
        pick = '0;
        for (int i = CHANNELS - 1; i >= 0; i--) begin
            if (rem[i]) begin
                pick = CH_W'(i);
            end
        end
        pick_hot  = '0;
        pick_hot[pick] = 1'b1;
        rem_after = rem & ~pick_hot;
    end

    assign pick_report = (rep_cnt_reg < RCNT_W'(MAX_RESULTS));
    assign pick_last   = pick_report &&
                         ((rep_cnt_reg == RCNT_W'(MAX_RESULTS - 1)) || (rem_after == '0));

    // hold everything while a result waits on a stalled output
    assign adv      = !(b_valid_reg && b_report_reg) || !m_valid_reg || m_ready;
    assign a_fire   = head_valid && adv;
    assign head_pop = a_fire && (rem_after == '0);
    assign out_load = b_valid_reg && b_report_reg && adv;

    always_comb begin
        done_next    = done_reg;
        rep_cnt_next = rep_cnt_reg;
        if (a_fire) begin
            if (rem_after == '0) begin
                done_next    = '0;
                rep_cnt_next = '0;
            end else begin
                done_next    = done_reg | pick_hot;
                rep_cnt_next = pick_report ? rep_cnt_reg + 1'b1 : rep_cnt_reg;
            end
        end
    end

    // width from start time and epoch age
    always_comb begin
        if (fwd_valid_reg && (fwd_ch_reg == b_ch_reg)) begin
            start_time = fwd_time_reg;
        end else if (written_reg[b_ch_reg]) begin
            start_time = rd_data_reg;
        end else begin
            start_time = '0;
        end
        diff = b_time_reg - start_time;
        case (b_age_reg)
            AGE_ZERO: width = diff;
            AGE_ONE:  width = (b_time_reg >= start_time) ? TIME_MAX : diff;
            default:  width = TIME_MAX;
        endcase
    end

    always_comb begin
        written_next = written_reg;
        if (adv && b_valid_reg) begin
            written_next[b_ch_reg] = 1'b1;
        end
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rd_data_reg <= start_mem[pick];
            if (b_valid_reg) begin
                start_mem[b_ch_reg] <= b_time_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_ch_reg     <= pick;
            b_age_reg    <= head_age[pick];
            b_time_reg   <= head_time;
            b_level_reg  <= head_level[pick];
            b_report_reg <= pick_report;
            b_last_reg   <= pick_last;
            fwd_ch_reg   <= b_ch_reg;
            fwd_time_reg <= b_time_reg;
        end
        if (out_load) begin
            m_data_reg.channel_index <= IDX_W'(b_ch_reg);
            m_data_reg.ended_level   <= b_level_reg;
            m_data_reg.pulse_len     <= width;
            m_data_reg.last_of_run   <= b_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg      <= '0;
            rep_cnt_reg   <= '0;
            b_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            written_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            done_reg     <= done_next;
            rep_cnt_reg  <= rep_cnt_next;
            written_reg  <= written_next;
            m_valid_reg  <= m_valid_next;
            if (adv) begin
                b_valid_reg   <= head_valid;
                fwd_valid_reg <= b_valid_reg;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: hdl/multichannel_pulse_width_capture.sv
// ----------------------------------------------------------------------------
// multichannel_pulse_width_capture
// Per-channel pulse width capture from packed sensor level samples.
// ----------------------------------------------------------------------------
// One sample request is taken per clock while the four-entry event queue has
// room; samples with no level change never enter the queue, but like every
// sample they wait while the queue is full. Each changed channel then takes
// one pass through the drain pipeline, which has a single start-time memory
// port pair, so results leave at one per cycle while m_ready is high. An
// accepted sample passes the event queue, width stage and output register
// before m_valid rises. Instead of adding each delta per channel, the block
// keeps one global 32-bit time and stores per channel the time of its last
// change in a memory; a 2-bit epoch age per channel (carry crossings of the
// global time) decides saturation. Up to eight results per sample are
// reported in channel order, the last one flagged; further changed channels
// still restart silently. No clearing pass runs after reset: a per-channel
// written flag makes unwritten start times read as zero.
// ----------------------------------------------------------------------------
module multichannel_pulse_width_capture #(
    parameter int CHANNELS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mpwc_pkg::sample_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mpwc_pkg::result_t   m_data
);
    import mpwc_pkg::*;

    // event layout: mask, ended levels, ages, time stamp
    localparam int EVT_W = CHANNELS + CHANNELS + 2 * CHANNELS + TIME_W;

    logic                     sample_accept;
    logic                     evt_push;
    logic [CHANNELS-1:0]      evt_mask, evt_level;
    logic [CHANNELS-1:0][1:0] evt_age;
    logic [TIME_W-1:0]        evt_time;

    logic [EVT_W-1:0]         head_data;
    logic                     q_empty, q_full, head_pop;
    logic [CHANNELS-1:0]      head_mask, head_level;
    logic [CHANNELS-1:0][1:0] head_age;
    logic [TIME_W-1:0]        head_time;

    // accept whenever the queue can hold an event
    assign s_ready       = !q_full;
    assign sample_accept = s_valid && s_ready;

    mpwc_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .sample_accept (sample_accept),
        .sample        (s_data),
        .evt_push      (evt_push),
        .evt_mask      (evt_mask),
        .evt_level     (evt_level),
        .evt_age       (evt_age),
        .evt_time      (evt_time)
    );

    mpwc_evq #(
        .WIDTH (EVT_W)
    ) u_evq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (evt_push),
        .push_data ({evt_mask, evt_level, evt_age, evt_time}),
        .pop       (head_pop),
        .head_data (head_data),
        .empty     (q_empty),
        .full      (q_full)
    );

    assign {head_mask, head_level, head_age, head_time} = head_data;

    mpwc_drain #(
        .CHANNELS (CHANNELS)
    ) u_drain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (!q_empty),
        .head_mask  (head_mask),
        .head_level (head_level),
        .head_age   (head_age),
        .head_time  (head_time),
        .head_pop   (head_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for multichannel_pulse_width_capture: sample requests
// go in through valid/ready, a predictor keeps per-channel levels and
// saturating elapsed times, and every result request is compared in order
// with the predicted one while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mpwc_pkg::*;

    localparam int NUM_CH      = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 16;

    logic    aclk = 1'b0;
    logic    aresetn;
    logic    s_valid;
    logic    s_ready;
    sample_t s_data;
    logic    m_valid;
    logic    m_ready = 1'b0;
    result_t m_data;

    // Predictor state: level held per channel and time since its last change.
    logic [NUM_CH-1:0] chan_level;
    logic [TIME_W-1:0] chan_elapsed [NUM_CH];

    // Results predicted for accepted samples, oldest first.
    result_t pending_results [$];
    result_t want;

    int error_count  = 0;
    int cycle_count  = 0;
    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int sink_hold_req = 0;
    int sink_hold_left = 0;

    // Level byte of the sender's last accepted request, top eight bits of level_bits.
    logic [NUM_CH-1:0] sent_level = '0;

    multichannel_pulse_width_capture #(
        .CHANNELS (NUM_CH)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Abort a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor: advance every channel by the delta, saturating at the top of
    // the 32-bit range, and queue one result per channel whose level flips, up
    // to MAX_RESULTS per sample. The width reported includes this sample's delta;
    // the channel then restarts from zero with the new level. The last result
    // of a sample is flagged.
    // ------------------------------------------------------------------------
    function automatic void predict_sample(input sample_t smp);
        result_t     r;
        int          n;
        logic        lvl;
        logic [32:0] sum;
        n = 0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            lvl = smp.level_bits[LEVEL_MSB - ch];
            sum = {1'b0, chan_elapsed[ch]} + {1'b0, smp.time_delta};
            chan_elapsed[ch] = sum[32] ? TIME_MAX : sum[TIME_W-1:0];
            if (lvl != chan_level[ch]) begin
                if (n < MAX_RESULTS) begin
                    r.channel_index = IDX_W'(ch);
                    r.ended_level   = chan_level[ch];
                    r.pulse_len     = chan_elapsed[ch];
                    r.last_of_run   = 1'b0;
                    pending_results.push_back(r);
                    n++;
                end
                chan_level[ch]   = lvl;
                chan_elapsed[ch] = '0;
            end
        end
        if (n > 0)
            pending_results[pending_results.size() - 1].last_of_run = 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: optionally idle, then offer one request and hold it until the
    // block takes it. Valid stays high on return so back-to-back requests need
    // no drop in between; call drop_request once a burst is over.
    // Handshakes are sampled at the falling edge, where everything driven at
    // the rising edge has settled; acceptance then happens at the next rise.
    // ------------------------------------------------------------------------
    task automatic send_sample(input logic [LEVEL_W-1:0] lvl_bits,
                               input logic [TIME_W-1:0] delta);
        sample_t smp;
        smp.level_bits = lvl_bits;
        smp.time_delta = delta;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= smp;
        @(negedge aclk);
        while (!s_ready)
            @(negedge aclk);
        @(posedge aclk);
        predict_sample(smp);
        sent_level = lvl_bits[LEVEL_MSB -: NUM_CH];
    endtask

    task automatic drop_request();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Send with random content below the channel bits, which the block ignores.
    task automatic send_levels(input logic [NUM_CH-1:0] lvl, input logic [TIME_W-1:0] delta);
        logic [LEVEL_W-1:0] bits;
        bits = $urandom;
        bits[LEVEL_MSB -: NUM_CH] = lvl;
        send_sample(bits, delta);
    endtask

    // Mostly short gaps, some long ones, a few across the full range.
    function automatic logic [TIME_W-1:0] pick_delta();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 10)
            return '0;
        else if (sel < 60)
            return TIME_W'($urandom_range(1, 1000));
        else if (sel < 85)
            return TIME_W'($urandom_range(0, 32'h00FF_FFFF));
        else if (sel < 92)
            return TIME_W'($urandom_range(32'hF000_0000, 32'hFFFF_FFFF));
        return $urandom;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: random stalls by percentage, or a long hold-off when asked.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (sink_hold_req > 0) begin
            sink_hold_left = sink_hold_req;
            sink_hold_req  = 0;
            m_ready <= 1'b0;
        end else if (sink_hold_left > 0) begin
            sink_hold_left = sink_hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Check each result request against the oldest prediction.
    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result ch=%0d lvl=%0d width=%h last=%0d",
                         $time, m_data.channel_index, m_data.ended_level,
                         m_data.pulse_len, m_data.last_of_run);
            end else begin
                want = pending_results.pop_front();
                if (m_data.channel_index !== want.channel_index ||
                    m_data.ended_level   !== want.ended_level ||
                    m_data.pulse_len     !== want.pulse_len ||
                    m_data.last_of_run   !== want.last_of_run) begin
                    error_count++;
                    $display("%0t: mismatch exp ch=%0d lvl=%0d width=%h last=%0d",
                             $time, want.channel_index, want.ended_level,
                             want.pulse_len, want.last_of_run);
                    $display("%0t:          got ch=%0d lvl=%0d width=%h last=%0d",
                             $time, m_data.channel_index, m_data.ended_level,
                             m_data.pulse_len, m_data.last_of_run);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Samples matching the reset levels produce nothing but still age channels.
    task automatic test_quiet_samples();
        send_levels('0, '0);
        send_levels('0, 32'd7);
        send_levels('0, 32'd1000);
        drop_request();
    endtask

    // Lone edges at both ends, every channel at once, and alternating patterns.
    task automatic test_channel_edges();
        send_levels(8'h80, 32'd5);
        send_levels(8'h81, 32'd3);
        send_levels(8'h01, 32'd0);
        send_levels(8'hFF, 32'd11);
        send_levels(8'h00, 32'd13);
        send_levels(8'hAA, 32'd17);
        send_levels(8'h55, 32'd19);
        send_levels(8'h00, 32'd23);
        drop_request();
    endtask

    // Sums that hit the maximum exactly, overflow once, overflow repeatedly,
    // and a global wrap that must not saturate a recently restarted channel.
    task automatic test_width_saturation();
        send_levels(8'h00, 32'hFFFF_FFFE);
        send_levels(8'h40, 32'h0000_0001);
        send_levels(8'h40, 32'h8000_0000);
        send_levels(8'h00, 32'h8000_0000);
        send_levels(8'h00, 32'hFFFF_FFFF);
        send_levels(8'h00, 32'hFFFF_FFFF);
        send_levels(8'h10, 32'hFFFF_FFFF);
        send_levels(8'h30, 32'hF000_0000);
        send_levels(8'h10, 32'h2000_0000);
        send_levels(8'h00, 32'h0000_0000);
        drop_request();
    endtask

    // Hold off the receiver while full-width flips keep coming so the block
    // fills up and must stall its input.
    task automatic test_output_backpressure();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        sink_hold_req = 300;
        for (int i = 0; i < 24; i++)
            send_levels(~sent_level, pick_delta());
        drop_request();
    endtask

    // Random flips per channel: many samples change nothing, some change a
    // few channels, a few flip everything.
    task automatic test_random_traffic(input int count, input int src_pct,
                                       input int sink_pct);
        logic [NUM_CH-1:0] flips;
        int sel;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 30)
                flips = '0;
            else if (sel < 90)
                flips = NUM_CH'($urandom) & NUM_CH'($urandom);
            else
                flips = '1;
            send_levels(sent_level ^ flips, pick_delta());
        end
        drop_request();
    endtask

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        chan_level = '0;
        for (int ch = 0; ch < NUM_CH; ch++)
            chan_elapsed[ch] = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_quiet_samples();
        test_channel_edges();
        test_width_saturation();
        test_output_backpressure();
        test_random_traffic(38, 8, 50);
        test_random_traffic(38, 50, 8);
        test_random_traffic(38, 0, 0);

        // Drain outstanding results, then give stray ones time to show up.
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
